// ----- hw/rtl/mmm_pkg.sv -----
// Shared types and constants for the matrix multiply unit.
// No dependencies; imported by mmm_ctrl, mmm_datapath and matrix_matrix_multiply.
`timescale 1ns / 1ps

package mmm_pkg;

   localparam int FUNC_W     = 2;
   localparam int IDX_W      = 5;
   localparam int IN_ELEM_W  = 16;
   localparam int SUM_W      = 37;
   localparam int DIM_W      = 6;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD_A  = 2'd0,
      FUNC_LOAD_B  = 2'd1,
      FUNC_COMPUTE = 2'd2
   } func_type;

   localparam logic [1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [1:0] CSR_COLS_B    = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load_a;
      logic load_b;
      logic mac_valid;
      logic first;
      logic last_k;
      logic last_c;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic s1_valid;
      logic s2_valid;
   } status_type;

endpackage

// ----- hw/rtl/matrix_matrix_multiply.sv -----
// Top level of the matrix multiply unit: register file, controller and datapath.
// Depends on mmm_pkg, mmm_ctrl and mmm_datapath.
`timescale 1ns / 1ps

// Load beats (func 0/1) write one element of A or B and never raise busy. A compute
// beat for row r keeps busy high while it does one multiply-accumulate per cycle
// through a single MAC fed by one read port on each store, and while it drains the
// read, multiply and accumulate stages. Results come out one per column, in column
// order, the last in the final busy cycle; rsp_valid is a one-cycle strobe and must be
// captured when seen, as there is no back-pressure.
// The user must write the dimension registers only while busy is low; the block
// itself does not enforce this.
module matrix_matrix_multiply #(
   parameter int MAX_DIM    = 32,
   parameter int ELEM_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [mmm_pkg::FUNC_W-1:0]           req_func,
   input  logic [mmm_pkg::IDX_W-1:0]            req_row_index,
   input  logic [mmm_pkg::IDX_W-1:0]            req_col_index,
   input  logic signed [mmm_pkg::IN_ELEM_W-1:0] req_element,
   output logic                                 rsp_valid,
   output logic signed [mmm_pkg::SUM_W-1:0]     rsp_product_sum,
   output logic [mmm_pkg::IDX_W-1:0]            rsp_out_row,
   output logic [mmm_pkg::IDX_W-1:0]            rsp_out_col,
   output logic                                 rsp_last,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mmm_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [mmm_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [mmm_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import mmm_pkg::*;

   localparam int IW = $clog2(MAX_DIM);
   localparam int DW = $clog2(MAX_DIM + 1);

   logic [DIM_W-1:0] rows_a_ff;
   logic [DIM_W-1:0] inner_dim_ff;
   logic [DIM_W-1:0] cols_b_ff;

   logic             csr_write;
   logic [1:0]       csr_index;
   logic [DW-1:0]    dim_rows;
   logic [DW-1:0]    dim_inner;
   logic [DW-1:0]    dim_cols;

   cmd_type          cmd;
   status_type       status;
   logic [IDX_W-1:0] rd_row;
   logic [IW-1:0]    rd_k;
   logic [IW-1:0]    rd_c;

   // zero reads as one, anything above MAX_DIM as MAX_DIM
   function automatic logic [DW-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DW-1:0] r;
      if (v == '0) begin
         r = DW'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = DW'(MAX_DIM);
      end else begin
         r = DW'(v);
      end
      return r;
   endfunction

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DIM_W'(1);
         inner_dim_ff <= DIM_W'(1);
         cols_b_ff    <= DIM_W'(1);
      end else if (csr_write) begin
         case (csr_index)
            CSR_ROWS_A:    rows_a_ff    <= csr_pwdata[DIM_W-1:0];
            CSR_INNER_DIM: inner_dim_ff <= csr_pwdata[DIM_W-1:0];
            CSR_COLS_B:    cols_b_ff    <= csr_pwdata[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_ROWS_A:    csr_prdata = CSR_DATA_W'(rows_a_ff);
         CSR_INNER_DIM: csr_prdata = CSR_DATA_W'(inner_dim_ff);
         CSR_COLS_B:    csr_prdata = CSR_DATA_W'(cols_b_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign dim_rows  = clamp_dim(rows_a_ff);
   assign dim_inner = clamp_dim(inner_dim_ff);
   assign dim_cols  = clamp_dim(cols_b_ff);

   mmm_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .func      (req_func),
      .row_index (req_row_index),
      .col_index (req_col_index),
      .dim_rows  (dim_rows),
      .dim_inner (dim_inner),
      .dim_cols  (dim_cols),
      .status    (status),
      .busy      (busy),
      .cmd       (cmd),
      .rd_row    (rd_row),
      .rd_k      (rd_k),
      .rd_c      (rd_c)
   );

   mmm_datapath #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .wr_row          (req_row_index),
      .wr_col          (req_col_index),
      .wr_element      (req_element),
      .rd_row          (rd_row),
      .rd_k            (rd_k),
      .rd_c            (rd_c),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_product_sum (rsp_product_sum),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_last        (rsp_last)
   );

`ifndef NO_ASSERTIONS
   // a result only appears while a compute beat is in hand
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat outside a compute");

   // loads, unused codes and rows beyond rows_a leave the unit free
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !((req_func == FUNC_COMPUTE) &&
       (32'(req_row_index) < 32'(dim_rows)))) |=> !busy)
      else $error("non-compute beat raised busy");

   // a valid compute beat always starts the sequencer
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_func == FUNC_COMPUTE) &&
       (32'(req_row_index) < 32'(dim_rows))) |=> busy)
      else $error("compute beat dropped");

   // the closing beat of a row is never followed straight away by another
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("result beat after end of row");
`endif

endmodule

// ----- hw/rtl/mmm_ctrl.sv -----
// Controller for the matrix multiply unit: beat decode and the k/c sequencer.
// Depends on mmm_pkg; drives mmm_datapath through cmd_type and status_type.
`timescale 1ns / 1ps

module mmm_ctrl #(
   parameter int MAX_DIM = 32,
   localparam int IW = $clog2(MAX_DIM),
   localparam int DW = $clog2(MAX_DIM + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [mmm_pkg::FUNC_W-1:0]   func,
   input  logic [mmm_pkg::IDX_W-1:0]    row_index,
   input  logic [mmm_pkg::IDX_W-1:0]    col_index,
   input  logic [DW-1:0]                dim_rows,
   input  logic [DW-1:0]                dim_inner,
   input  logic [DW-1:0]                dim_cols,
   input  mmm_pkg::status_type          status,
   output logic                         busy,
   output mmm_pkg::cmd_type             cmd,
   output logic [mmm_pkg::IDX_W-1:0]    rd_row,
   output logic [IW-1:0]                rd_k,
   output logic [IW-1:0]                rd_c
);
   import mmm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   state_type          state_ff;
   logic               mac_valid_ff;
   logic [IDX_W-1:0]   row_ff;
   logic [IW-1:0]      k_ff;
   logic [IW-1:0]      c_ff;

   logic accept;
   logic in_range;
   logic is_compute;
   logic last_k;
   logic last_c;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start & ~busy;
   assign in_range   = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
   assign is_compute = accept && (func == FUNC_COMPUTE) && (32'(row_index) < 32'(dim_rows));
   assign last_k     = (DW'(k_ff) == dim_inner - DW'(1));
   assign last_c     = (DW'(c_ff) == dim_cols - DW'(1));

   assign cmd.load_a    = accept && (func == FUNC_LOAD_A) && in_range;
   assign cmd.load_b    = accept && (func == FUNC_LOAD_B) && in_range;
   assign cmd.mac_valid = mac_valid_ff;
   assign cmd.first     = (k_ff == '0);
   assign cmd.last_k    = last_k;
   assign cmd.last_c    = last_c;

   assign rd_row = row_ff;
   assign rd_k   = k_ff;
   assign rd_c   = c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mac_valid_ff <= 1'b0;
         row_ff       <= '0;
         k_ff         <= '0;
         c_ff         <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (is_compute) begin
                  state_ff     <= ST_RUN;
                  mac_valid_ff <= 1'b1;
                  row_ff       <= row_index;
                  k_ff         <= '0;
                  c_ff         <= '0;
               end
            end
            ST_RUN: begin
               if (last_k) begin
                  k_ff <= '0;
                  if (last_c) begin
                     state_ff     <= ST_DRAIN;
                     mac_valid_ff <= 1'b0;
                  end else begin
                     c_ff <= c_ff + IW'(1);
                  end
               end else begin
                  k_ff <= k_ff + IW'(1);
               end
            end
            ST_DRAIN: begin
               if (!(status.s1_valid || status.s2_valid)) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               mac_valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

// ----- hw/rtl/mmm_datapath.sv -----
// Datapath for the matrix multiply unit: element stores, MAC pipeline, result register.
// Depends on mmm_pkg; commanded by mmm_ctrl.
`timescale 1ns / 1ps

module mmm_datapath #(
   parameter int MAX_DIM    = 32,
   parameter int ELEM_WIDTH = 16,
   localparam int IW = $clog2(MAX_DIM)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mmm_pkg::cmd_type                    cmd,
   input  logic [mmm_pkg::IDX_W-1:0]           wr_row,
   input  logic [mmm_pkg::IDX_W-1:0]           wr_col,
   input  logic signed [mmm_pkg::IN_ELEM_W-1:0] wr_element,
   input  logic [mmm_pkg::IDX_W-1:0]           rd_row,
   input  logic [IW-1:0]                       rd_k,
   input  logic [IW-1:0]                       rd_c,
   output mmm_pkg::status_type                 status,
   output logic                                rsp_valid,
   output logic signed [mmm_pkg::SUM_W-1:0]    rsp_product_sum,
   output logic [mmm_pkg::IDX_W-1:0]           rsp_out_row,
   output logic [mmm_pkg::IDX_W-1:0]           rsp_out_col,
   output logic                                rsp_last
);
   import mmm_pkg::*;

   localparam int AW    = 2 * IW;
   localparam int DEPTH = 1 << AW;
   localparam int PW    = 2 * ELEM_WIDTH;

   logic [ELEM_WIDTH-1:0] store_a_ff [DEPTH];
   logic [ELEM_WIDTH-1:0] store_b_ff [DEPTH];

   logic [AW-1:0]          wr_addr;
   logic [AW-1:0]          rd_addr_a;
   logic [AW-1:0]          rd_addr_b;
   logic [ELEM_WIDTH-1:0]  wr_data;

   logic signed [ELEM_WIDTH-1:0] a_rd_ff;
   logic signed [ELEM_WIDTH-1:0] b_rd_ff;
   logic signed [PW-1:0]         prod_ff;
   logic signed [SUM_W-1:0]      prod_ext;
   logic signed [SUM_W-1:0]      acc_ff;
   logic signed [SUM_W-1:0]      sum_in;

   logic          s1_valid_ff, s1_first_ff, s1_last_k_ff, s1_last_c_ff;
   logic          s2_valid_ff, s2_first_ff, s2_last_k_ff, s2_last_c_ff;
   logic [IW-1:0] s1_col_ff, s2_col_ff;

   logic               rsp_valid_ff;
   logic signed [SUM_W-1:0] rsp_sum_ff;
   logic [IDX_W-1:0]   rsp_row_ff;
   logic [IDX_W-1:0]   rsp_col_ff;
   logic               rsp_last_ff;

   assign wr_addr   = {IW'(wr_row), IW'(wr_col)};
   assign wr_data   = ELEM_WIDTH'(wr_element);
   assign rd_addr_a = {IW'(rd_row), rd_k};
   assign rd_addr_b = {rd_k, rd_c};

   always_ff @(posedge clock) begin
      if (cmd.load_a) begin
         store_a_ff[wr_addr] <= wr_data;
      end
      a_rd_ff <= store_a_ff[rd_addr_a];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_b) begin
         store_b_ff[wr_addr] <= wr_data;
      end
      b_rd_ff <= store_b_ff[rd_addr_b];
   end

   // product is sign-extended into the 37-bit sum
   assign prod_ext = SUM_W'(prod_ff);
   assign sum_in   = s2_first_ff ? prod_ext : acc_ff + prod_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= cmd.mac_valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff & s2_last_k_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff  <= cmd.first;
      s1_last_k_ff <= cmd.last_k;
      s1_last_c_ff <= cmd.last_c;
      s1_col_ff    <= rd_c;
      s2_first_ff  <= s1_first_ff;
      s2_last_k_ff <= s1_last_k_ff;
      s2_last_c_ff <= s1_last_c_ff;
      s2_col_ff    <= s1_col_ff;
      prod_ff      <= PW'(a_rd_ff) * PW'(b_rd_ff);
      if (s2_valid_ff) begin
         acc_ff <= sum_in;
      end
      if (s2_valid_ff && s2_last_k_ff) begin
         rsp_sum_ff  <= sum_in;
         rsp_row_ff  <= rd_row;
         rsp_col_ff  <= IDX_W'(s2_col_ff);
         rsp_last_ff <= s2_last_c_ff;
      end
   end

   assign status.s1_valid = s1_valid_ff;
   assign status.s2_valid = s2_valid_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_product_sum = rsp_sum_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_out_col     = rsp_col_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
